// ===== rtl/tcte_pkg.sv =====
package tcte_pkg;

  localparam int COORD_W = 8;
  localparam int OFF_W   = 16;
  localparam int ADDR_W  = 18;
  localparam int CELL_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam int TCTE_PAGES      = 8;
  localparam int TCTE_PAGE_BYTES = 4096;

  // command codes
  localparam logic [2:0] CMD_SET_CURSOR = 3'd0;
  localparam logic [2:0] CMD_GET_CURSOR = 3'd1;
  localparam logic [2:0] CMD_SEL_PAGE   = 3'd2;
  localparam logic [2:0] CMD_TELETYPE   = 3'd3;
  localparam logic [2:0] CMD_READ_CHAR  = 3'd4;
  localparam logic [2:0] CMD_WRITE_CA   = 3'd5;
  localparam logic [2:0] CMD_WRITE_CHAR = 3'd6;
  localparam logic [2:0] CMD_UNUSED     = 3'd7;

  // video memory request codes
  localparam logic [1:0] MEM_NONE     = 2'd0;
  localparam logic [1:0] MEM_READ     = 2'd1;
  localparam logic [1:0] MEM_WRITE    = 2'd2;
  localparam logic [1:0] MEM_WRITE_LO = 2'd3;

  // CRTC update codes
  localparam logic [1:0] CRTC_NONE   = 2'd0;
  localparam logic [1:0] CRTC_CURSOR = 2'd1;
  localparam logic [1:0] CRTC_START  = 2'd2;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW       = 1'b1;
  localparam logic [COORD_W-1:0]   COLUMNS_RESET      = 8'd80;
  localparam logic [COORD_W-1:0]   LAST_ROW_RESET     = 8'd24;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         page;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [7:0]         char_code;
    logic [7:0]         attribute;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [COORD_W-1:0] cursor_row_out;
    logic [COORD_W-1:0] cursor_col_out;
    logic [1:0]         mem_op;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_data;
    logic [1:0]         crtc_op;
    logic [15:0]        crtc_value;
    logic               scroll_request;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OLD,
    S_NEW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic old_phase;
    logic new_phase;
    logic finish;
  } ctrl_t;

endpackage

// ===== rtl/text_cursor_teletype_engine.sv =====
// A command accepted while idle steps through the old-cursor, new-cursor and commit states;
//   the registered result beat follows on done, and no new command is taken until idle again.
// The shared multiply-add runs twice per command (old cursor cell offset, then new cursor offset).
// Results leave on a one-cycle done strobe; the receiver cannot stall.
// Reset (rst, synchronous): cursor table zero, active page 0, 80 columns, last row 24.
module text_cursor_teletype_engine import tcte_pkg::*; #(
  parameter int PAGES      = TCTE_PAGES,
  parameter int PAGE_BYTES = TCTE_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  item_t                item,
  output logic                 busy,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [8:0] PAGE_LIMIT = 9'(PAGES);

  // ---------------------------------------------------------------------------
  // Configuration registers: the user writes them only while the engine is idle; not enforced here.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] screen_columns;
  logic [COORD_W-1:0] last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= COLUMNS_RESET;
      last_row       <= LAST_ROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_COLUMNS: screen_columns <= cfg_data;
        CFG_LAST_ROW:       last_row       <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  ctrl_t ctrl;

  tcte_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctrl  (ctrl)
  );

  assign busy = ctrl.busy;

  // Command beat is captured at acceptance and held for the whole command.
  item_t item_q;

  always_ff @(posedge clk) begin
    if (start && !ctrl.busy) item_q <= item;
  end

  // ---------------------------------------------------------------------------
  // Cursor table: one row/column word per page, plus the active page.
  // Single read address (the command's page), so plain flops are enough.
  // ---------------------------------------------------------------------------
  logic [2*COORD_W-1:0] cursor_table [PAGES];
  logic [PAGE_W-1:0]    active_page;
  logic [PAGE_W-1:0]    page_idx;
  logic                 page_ok;
  logic [COORD_W-1:0]   cur_row;
  logic [COORD_W-1:0]   cur_col;

  assign page_idx = item_q.page[PAGE_W-1:0];
  assign page_ok  = ({1'b0, item_q.page} < PAGE_LIMIT);
  assign cur_row  = cursor_table[page_idx][2*COORD_W-1:COORD_W];
  assign cur_col  = cursor_table[page_idx][COORD_W-1:0];

  // ---------------------------------------------------------------------------
  // Old-cursor phase: latch the stored cursor and work out the new one.
  // Teletype bumps the column; a match with screen_columns wraps to column 0 and
  // moves down a row, except on the last row, where the row holds and a scroll
  // is requested instead.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] old_row, old_col;
  logic [COORD_W-1:0] new_row, new_col;
  logic               scroll_q;
  logic [COORD_W-1:0] adv_row, adv_col;
  logic               adv_scroll;

  always_comb begin
    adv_row    = cur_row;
    adv_col    = cur_col + 8'd1;
    adv_scroll = 1'b0;
    if (adv_col == screen_columns) begin
      adv_col = '0;
      if (cur_row == last_row) begin
        adv_scroll = 1'b1;
      end else begin
        adv_row = cur_row + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.old_phase) begin
      old_row <= cur_row;
      old_col <= cur_col;
      if (item_q.cmd == CMD_SET_CURSOR) begin
        new_row  <= item_q.row;
        new_col  <= item_q.column;
        scroll_q <= 1'b0;
      end else begin
        new_row  <= adv_row;
        new_col  <= adv_col;
        scroll_q <= adv_scroll;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-add: row*screen_columns + col.
  // Old phase feeds the stored cursor, new phase feeds the updated one; the old
  // offset is parked in off_old while the unit works on the new offset.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] mac_a, mac_c;
  logic [OFF_W-1:0]   mac_q;
  logic [OFF_W-1:0]   off_old;

  assign mac_a = ctrl.new_phase ? new_row : cur_row;
  assign mac_c = ctrl.new_phase ? new_col : cur_col;

  tcte_mac u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (screen_columns),
    .c   (mac_c),
    .q   (mac_q)
  );

  always_ff @(posedge clk) begin
    if (ctrl.new_phase) off_old <= mac_q;
  end

  // ---------------------------------------------------------------------------
  // Commit phase: build the result beat and update table / active page.
  // ---------------------------------------------------------------------------
  logic [31:0]       base_full;
  logic [ADDR_W-1:0] cell_addr;
  logic              on_active;
  result_t           res;
  logic              tbl_we;
  logic              act_we;

  assign base_full = 32'(page_idx) * 32'(PAGE_BYTES);
  assign cell_addr = base_full[ADDR_W-1:0] + {1'b0, off_old, 1'b0};
  assign on_active = (page_idx == active_page);

  always_comb begin
    res    = '0;
    tbl_we = 1'b0;
    act_we = 1'b0;
    if (item_q.cmd != CMD_UNUSED) begin
      if (!page_ok) begin
        res.status = 1'b1;
      end else begin
        unique case (item_q.cmd)
          CMD_SET_CURSOR: begin
            tbl_we = 1'b1;
            if (on_active) begin
              res.crtc_op    = CRTC_CURSOR;
              res.crtc_value = mac_q;
            end
          end
          CMD_GET_CURSOR: begin
            res.cursor_row_out = old_row;
            res.cursor_col_out = old_col;
          end
          CMD_SEL_PAGE: begin
            if (!on_active) begin
              act_we         = 1'b1;
              res.crtc_op    = CRTC_START;
              res.crtc_value = base_full[15:0];
            end
          end
          CMD_TELETYPE: begin
            tbl_we             = 1'b1;
            res.mem_op         = MEM_WRITE;
            res.mem_addr       = cell_addr;
            res.mem_data       = {item_q.attribute, item_q.char_code};
            res.scroll_request = scroll_q;
            if (on_active) begin
              res.crtc_op    = CRTC_CURSOR;
              res.crtc_value = mac_q;
            end
          end
          CMD_READ_CHAR: begin
            res.mem_op   = MEM_READ;
            res.mem_addr = cell_addr;
          end
          CMD_WRITE_CA: begin
            res.mem_op   = MEM_WRITE;
            res.mem_addr = cell_addr;
            res.mem_data = {item_q.attribute, item_q.char_code};
          end
          CMD_WRITE_CHAR: begin
            res.mem_op   = MEM_WRITE_LO;
            res.mem_addr = cell_addr;
            res.mem_data = {8'd0, item_q.char_code};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGES; i++) cursor_table[i] <= '0;
      active_page <= '0;
    end else if (ctrl.finish) begin
      if (tbl_we) cursor_table[page_idx] <= {new_row, new_col};
      if (act_we) active_page <= page_idx;
    end
  end

  // Result beat: registered, one-cycle done strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) result <= res;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result beat not 4 cycles after command");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("more than one result beat per command");

  a_idle_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("engine busy while presenting result");

  a_bad_page_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |->
      (result.mem_op == MEM_NONE && result.crtc_op == CRTC_NONE && !result.scroll_request))
    else $error("rejected page still issued a request");

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    32'(active_page) < PAGES)
    else $error("active page out of range");

endmodule

// ===== rtl/tcte_mac.sv =====
// Shared multiply-add: q = a*b + c, registered. Serves both cursor offsets.
module tcte_mac import tcte_pkg::*; (
  input  logic               clk,
  input  logic [COORD_W-1:0] a,
  input  logic [COORD_W-1:0] b,
  input  logic [COORD_W-1:0] c,
  output logic [OFF_W-1:0]   q
);

  logic [OFF_W-1:0] prod;

  assign prod = {8'd0, a} * {8'd0, b};

  // max 255*255+255 fits in 16 bits
  always_ff @(posedge clk) begin
    q <= prod + {8'd0, c};
  end

endmodule

// ===== rtl/tcte_seq.sv =====
// Command sequencer: old-cursor offset, new-cursor offset, commit.
module tcte_seq import tcte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_OLD;
      end
      S_OLD:  state_next = S_NEW;
      S_NEW:  state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.busy      = (state != S_IDLE);
    ctrl.old_phase = (state == S_OLD);
    ctrl.new_phase = (state == S_NEW);
    ctrl.finish    = (state == S_DONE);
  end

endmodule
